### sv/accm_pkg.sv
// Shared types, constants and AES helpers for the CCM seal/open unit.
package accm_pkg;

   localparam int MaxAadBytes     = 1024;
   localparam int MaxPayloadBytes = 4096;

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_AAD     = 2'd1,
      ACT_PAYLOAD = 2'd2,
      ACT_FINISH  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_FINAL   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_LEN  = 2'd1,
      ST_AUTH     = 2'd2,
      ST_SEQUENCE = 2'd3
   } status_type;

   typedef enum logic {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  action;
      logic        decrypt;
      logic [39:0] nonce_high;
      logic [63:0] nonce_low;
      logic [15:0] aad_length;
      logic [15:0] payload_length;
      logic [4:0]  tag_length;
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic [4:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic [4:0]  data_count;
      logic [63:0] tag_high;
      logic [63:0] tag_low;
      logic [1:0]  status;
   } rsp_type;

   // AES command from sequencer to round unit
   typedef struct packed {
      logic         start;
      logic [127:0] block;
   } aes_cmd_type;

   typedef struct packed {
      logic         done;
      logic [127:0] result;
   } aes_res_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit block, byte 0 in the top bits
   function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
      byte_at = v[127 - 8 * i -: 8];
   endfunction

   // keep the first n bytes, zero the rest
   function automatic logic [127:0] keep_bytes(input logic [127:0] v, input logic [4:0] n);
      logic [127:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < n) begin
            r[127 - 8 * i -: 8] = v[127 - 8 * i -: 8];
         end
      end
      keep_bytes = r;
   endfunction

endpackage

### sv/accm_round.sv
// Iterative AES-128 encryption core: one round per cycle, key expanded on the fly.
module accm_round (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [127:0]          key,
   input  accm_pkg::aes_cmd_type cmd,
   output accm_pkg::aes_res_type res
);
   import accm_pkg::*;

   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   round_ff, round_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   logic [127:0] sub_shift, mixed, next_key;

   always_comb begin
      logic [7:0] a0, a1, a2, a3, x, t0, t1, t2, t3;
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            sub_shift[127 - 8 * (c * 4 + w) -: 8] =
               SBOX[byte_at(state_ff, ((c + w) % 4) * 4 + w)];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = byte_at(sub_shift, c * 4);
         a1 = byte_at(sub_shift, c * 4 + 1);
         a2 = byte_at(sub_shift, c * 4 + 2);
         a3 = byte_at(sub_shift, c * 4 + 3);
         x  = a0 ^ a1 ^ a2 ^ a3;
         t0 = a0 ^ x ^ xtime(a0 ^ a1);
         t1 = a1 ^ x ^ xtime(a1 ^ a2);
         t2 = a2 ^ x ^ xtime(a2 ^ a3);
         t3 = a3 ^ x ^ xtime(a3 ^ a0);
         mixed[127 - 32 * c -: 32] = {t0, t1, t2, t3};
      end
      next_key[127:96] = rkey_ff[127:96] ^ {SBOX[byte_at(rkey_ff, 13)] ^ rcon_ff,
         SBOX[byte_at(rkey_ff, 14)], SBOX[byte_at(rkey_ff, 15)], SBOX[byte_at(rkey_ff, 12)]};
      next_key[95:64]  = rkey_ff[95:64] ^ next_key[127:96];
      next_key[63:32]  = rkey_ff[63:32] ^ next_key[95:64];
      next_key[31:0]   = rkey_ff[31:0]  ^ next_key[63:32];
   end

   always_comb begin
      state_in = state_ff;
      rkey_in  = rkey_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         state_in = cmd.block ^ key;
         rkey_in  = key;
         rcon_in  = 8'h01;
         round_in = 4'd1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         state_in = ((round_ff == 4'd10) ? sub_shift : mixed) ^ next_key;
         rkey_in  = next_key;
         rcon_in  = xtime(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == 4'd10) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign res.done   = done_ff;
   assign res.result = state_ff;

endmodule

### sv/accm_queue.sv
// Two-entry item queue between the front end and the back end.
module accm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  accm_pkg::req_type push_item,
   output logic              full,
   input  logic              pop,
   output accm_pkg::req_type pop_item,
   output logic              empty
);
   import accm_pkg::*;

   req_type    mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wptr_ff] <= push_item;
      end
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push && !full) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop && !empty) begin
            rptr_ff <= ~rptr_ff;
         end
         count_ff <= count_ff + 2'(push && !full) - 2'(pop && !empty);
      end
   end

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_item = mem_ff[rptr_ff];

endmodule

### sv/accm_engine.sv
// Back end: CCM message sequencer driving the shared AES round unit.
module accm_engine #(
   parameter int MAX_AAD_BYTES     = accm_pkg::MaxAadBytes,
   parameter int MAX_PAYLOAD_BYTES = accm_pkg::MaxPayloadBytes
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [127:0]      key,
   input  logic              item_empty,
   input  accm_pkg::req_type item,
   output logic              item_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output accm_pkg::rsp_type rsp_item
);
   import accm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_B0, S_AAD_LOOP, S_AAD_WAIT, S_CTR, S_CTR_WAIT, S_MAC, S_MAC_WAIT,
      S_TAG, S_TAG_WAIT, S_OUT
   } state_type;

   localparam logic [1:0] PH_IDLE = 2'd0, PH_AAD = 2'd1, PH_PAYLOAD = 2'd2,
                          PH_FINISH = 2'd3;

   state_type    state_ff;
   logic [127:0] mac_ff, stage_ff, blk_ff, ks_ff;
   logic [4:0]   fill_ff, idx_ff, cnt_ff, tagb_ff;
   logic [103:0] nonce_ff;
   logic [15:0]  ctr_ff, aad_rem_ff, pay_rem_ff;
   logic         open_ff, flush_ff;
   logic [1:0]   phase_ff;
   rsp_type      result_ff;
   rsp_type      rsp_ff;
   logic         rsp_valid_ff;
   aes_cmd_type  cmd;
   aes_res_type  res;

   accm_round u_round (
      .clock (clock),
      .reset (reset),
      .key   (key),
      .cmd   (cmd),
      .res   (res)
   );

   logic         start_bad;
   logic [4:0]   want;
   logic [127:0] ctr_block, pay_in, pay_out, tag_full, diff;
   logic [7:0]   b0_flags;

   always_comb begin
      start_bad = item.tag_length < 5'd4 || item.tag_length > 5'd16 || item.tag_length[0] ||
                  32'(item.aad_length) > 32'(MAX_AAD_BYTES) ||
                  32'(item.payload_length) > 32'(MAX_PAYLOAD_BYTES);
      want      = (pay_rem_ff > 16'd16) ? 5'd16 : pay_rem_ff[4:0];
      ctr_block = {8'h01, nonce_ff, ctr_ff};
      pay_in    = keep_bytes(blk_ff, cnt_ff);
      pay_out   = keep_bytes(pay_in ^ ks_ff, cnt_ff);
      tag_full  = keep_bytes(mac_ff ^ res.result, tagb_ff);
      diff      = tag_full ^ keep_bytes(blk_ff, tagb_ff);
      b0_flags  = {1'b0, item.aad_length != 16'd0, 3'(5'(item.tag_length - 5'd2) >> 1),
                   3'b001};
   end

   always_ff @(posedge clock) begin
      cmd.start <= 1'b0;
      item_pop  <= 1'b0;
      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_ff <= 1'b0;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
         mac_ff       <= '0;
         stage_ff     <= '0;
         fill_ff      <= '0;
         nonce_ff     <= '0;
         ctr_ff       <= 16'd1;
         aad_rem_ff   <= '0;
         pay_rem_ff   <= '0;
         tagb_ff      <= '0;
         open_ff      <= 1'b0;
         cmd.start    <= 1'b0;
         item_pop     <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (!item_empty && !item_pop) begin
                  item_pop  <= 1'b1;
                  blk_ff    <= {item.block_high, item.block_low};
                  cnt_ff    <= item.byte_count;
                  result_ff <= '0;
                  state_ff  <= S_OUT;
                  unique case (action_type'(item.action))
                     ACT_START: begin
                        if (start_bad) begin
                           phase_ff         <= PH_IDLE;
                           result_ff.status <= ST_BAD_LEN;
                        end else begin
                           nonce_ff   <= {item.nonce_high, item.nonce_low};
                           open_ff    <= item.decrypt;
                           tagb_ff    <= item.tag_length;
                           aad_rem_ff <= item.aad_length;
                           pay_rem_ff <= item.payload_length;
                           ctr_ff     <= 16'd1;
                           cmd.start  <= 1'b1;
                           cmd.block  <= {b0_flags, item.nonce_high, item.nonce_low,
                                          item.payload_length};
                           stage_ff   <= {item.aad_length, 112'd0};
                           fill_ff    <= (item.aad_length != 16'd0) ? 5'd2 : 5'd0;
                           if (item.aad_length != 16'd0) phase_ff <= PH_AAD;
                           else if (item.payload_length != 16'd0) phase_ff <= PH_PAYLOAD;
                           else phase_ff <= PH_FINISH;
                           state_ff <= S_B0;
                        end
                     end
                     ACT_AAD: begin
                        if (phase_ff != PH_AAD) begin
                           result_ff.status <= ST_SEQUENCE;
                        end else if (item.byte_count > 5'd16 ||
                                     16'(item.byte_count) > aad_rem_ff) begin
                           result_ff.status <= ST_BAD_LEN;
                        end else begin
                           idx_ff     <= '0;
                           aad_rem_ff <= aad_rem_ff - 16'(item.byte_count);
                           state_ff   <= S_AAD_LOOP;
                        end
                     end
                     ACT_PAYLOAD: begin
                        if (phase_ff != PH_PAYLOAD) begin
                           result_ff.status <= ST_SEQUENCE;
                        end else if (item.byte_count != want) begin
                           result_ff.status <= ST_BAD_LEN;
                        end else begin
                           state_ff <= S_CTR;
                        end
                     end
                     default: begin
                        if (phase_ff != PH_FINISH) begin
                           result_ff.status <= ST_SEQUENCE;
                        end else begin
                           state_ff <= S_TAG;
                        end
                     end
                  endcase
               end
            end
            S_B0: begin
               if (res.done) begin
                  mac_ff   <= res.result;
                  state_ff <= S_OUT;
               end
            end
            // one AAD byte a cycle into the staging block, pausing while each full block goes through the AES unit
            S_AAD_LOOP: begin
               if (idx_ff == cnt_ff) begin
                  if (aad_rem_ff == 16'd0 && fill_ff != 5'd0) begin
                     cmd.start <= 1'b1;
                     cmd.block <= mac_ff ^ stage_ff;
                     flush_ff  <= 1'b1;
                     state_ff  <= S_AAD_WAIT;
                  end else begin
                     if (aad_rem_ff == 16'd0) begin
                        phase_ff <= (pay_rem_ff != 16'd0) ? PH_PAYLOAD : PH_FINISH;
                     end
                     state_ff <= S_OUT;
                  end
               end else begin
                  idx_ff <= idx_ff + 5'd1;
                  if (fill_ff == 5'd15) begin
                     cmd.start <= 1'b1;
                     cmd.block <= mac_ff ^ {stage_ff[127:8], byte_at(blk_ff, int'(idx_ff[3:0]))};
                     flush_ff  <= 1'b0;
                     stage_ff  <= '0;
                     fill_ff   <= '0;
                     state_ff  <= S_AAD_WAIT;
                  end else begin
                     stage_ff[127 - 8 * fill_ff[3:0] -: 8] <=
                        byte_at(blk_ff, int'(idx_ff[3:0]));
                     fill_ff <= fill_ff + 5'd1;
                  end
               end
            end
            S_AAD_WAIT: begin
               if (res.done) begin
                  mac_ff <= res.result;
                  if (flush_ff) begin
                     stage_ff <= '0;
                     fill_ff  <= '0;
                     phase_ff <= (pay_rem_ff != 16'd0) ? PH_PAYLOAD : PH_FINISH;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_AAD_LOOP;
                  end
               end
            end
            S_CTR: begin
               cmd.start <= 1'b1;
               cmd.block <= ctr_block;
               state_ff  <= S_CTR_WAIT;
            end
            S_CTR_WAIT: begin
               if (res.done) begin
                  ks_ff    <= res.result;
                  state_ff <= S_MAC;
               end
            end
            S_MAC: begin
               cmd.start  <= 1'b1;
               cmd.block  <= mac_ff ^ (open_ff ? pay_out : pay_in);
               result_ff.kind       <= KIND_PAYLOAD;
               result_ff.data_high  <= pay_out[127:64];
               result_ff.data_low   <= pay_out[63:0];
               result_ff.data_count <= cnt_ff;
               ctr_ff     <= ctr_ff + 16'd1;
               pay_rem_ff <= pay_rem_ff - 16'(cnt_ff);
               if (pay_rem_ff == 16'(cnt_ff)) phase_ff <= PH_FINISH;
               state_ff   <= S_MAC_WAIT;
            end
            S_MAC_WAIT: begin
               if (res.done) begin
                  mac_ff   <= res.result;
                  state_ff <= S_OUT;
               end
            end
            S_TAG: begin
               cmd.start <= 1'b1;
               cmd.block <= {8'h01, nonce_ff, 16'd0};
               state_ff  <= S_TAG_WAIT;
            end
            S_TAG_WAIT: begin
               if (res.done) begin
                  result_ff.kind     <= KIND_FINAL;
                  result_ff.tag_high <= tag_full[127:64];
                  result_ff.tag_low  <= tag_full[63:0];
                  result_ff.status   <= (open_ff && diff != '0) ? ST_AUTH : ST_OK;
                  phase_ff           <= PH_IDLE;
                  state_ff           <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_pop) begin
                  rsp_ff       <= result_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### sv/aes128_ccm_seal_open_unit.sv
// Top level of the AES-128-CCM seal/open unit.
// Accepted items run on the single ten-round AES unit shared by CTR and CBC-MAC.
// The back end handles one item at a time; a two-entry queue buffers input and one
// output register holds the result.
// Reset: synchronous, active high; clears sequencing state, key registers read zero.
module aes128_ccm_seal_open_unit #(
   parameter int MAX_AAD_BYTES     = accm_pkg::MaxAadBytes,
   parameter int MAX_PAYLOAD_BYTES = accm_pkg::MaxPayloadBytes
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  accm_pkg::req_type req_item,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output accm_pkg::rsp_type rsp_item,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [63:0]       csr_data
);
   import accm_pkg::*;

   logic [63:0] key_high_ff, key_low_ff;
   logic        q_empty, q_pop;
   req_type     q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   accm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (req_item),
      .full      (req_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   accm_engine #(
      .MAX_AAD_BYTES     (MAX_AAD_BYTES),
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .key        ({key_high_ff, key_low_ff}),
      .item_empty (q_empty),
      .item       (q_item),
      .item_pop   (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_item   (rsp_item)
   );

endmodule
